@@ hdl/nearest_palette_colour_search_unit_macros.svh @@
// ----------------------------------------------------------------------------
// nearest_palette_colour_search_unit_macros
// Assertion macros shared by the palette search RTL.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOUR_SEARCH_UNIT_MACROS_SVH
`define NEAREST_PALETTE_COLOUR_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("npcs assertion failed");

// next-cycle implication
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("npcs assertion failed");

`endif

@@ hdl/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg
// Constants, types and helpers for the nearest palette colour search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int IDX_W         = 8;
  localparam int CHAN_W        = 8;
  localparam int COLOUR_W      = 3 * CHAN_W;
  localparam int DIST_W        = 10;
  localparam int CMP_W         = ((PAL_AW > IDX_W) ? PAL_AW : IDX_W) + 1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npcs_state_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

@@ hdl/nearest_palette_colour_search_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_colour_search_unit
// Palette store with nearest-colour (sum of absolute differences) lookup.
// ----------------------------------------------------------------------------
// Write item: stored in the palette, no result.
// Query item: reads one palette entry per cycle from the colour RAM, then the
//   result is loaded after the drain and finish states; one item at a time.
// A new item is taken once the query has moved its result to the output register.
// Reset clears every valid mark at once; no clearing pass, no wait after reset.
`default_nettype none
`include "nearest_palette_colour_search_unit_macros.svh"

module nearest_palette_colour_search_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         func,
  input  wire logic [npcs_pkg::IDX_W-1:0]   entry_index,
  input  wire logic [npcs_pkg::CHAN_W-1:0]  red,
  input  wire logic [npcs_pkg::CHAN_W-1:0]  green,
  input  wire logic [npcs_pkg::CHAN_W-1:0]  blue,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic                              found,
  output logic [npcs_pkg::IDX_W-1:0]        match_index,
  output logic [npcs_pkg::DIST_W-1:0]       match_distance
);
  import npcs_pkg::*;

  localparam logic [PAL_AW-1:0] LAST_IDX = PAL_AW'(PALETTE_DEPTH - 1);

  npcs_state_t state, state_next;

  logic [COLOUR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOUR_W-1:0] rd_data;
  logic [PALETTE_DEPTH-1:0] entry_valid;

  logic [PAL_AW-1:0] cnt;
  logic              rd_pend;
  logic [PAL_AW-1:0] rd_idx;
  logic              vld_q;

  logic [CHAN_W-1:0] q_red, q_green, q_blue;
  logic              have;
  logic [PAL_AW-1:0] best_idx;
  logic [DIST_W-1:0] best_dist;

  logic              accept, accept_wr, accept_qry, wr_in_range;
  logic [PAL_AW-1:0] wr_addr;
  logic              issue, load_out, take;
  logic [DIST_W-1:0] cand_dist;

  assign accept      = item_valid && !item_stall;
  assign accept_wr   = accept && (func == FUNC_WRITE);
  assign accept_qry  = accept && (func == FUNC_QUERY);
  assign wr_in_range = CMP_W'(entry_index) < CMP_W'(PALETTE_DEPTH);
  assign wr_addr     = PAL_AW'(entry_index);

  assign cand_dist = DIST_W'(abs_diff(rd_data[3*CHAN_W-1:2*CHAN_W], q_red))
                   + DIST_W'(abs_diff(rd_data[2*CHAN_W-1:CHAN_W], q_green))
                   + DIST_W'(abs_diff(rd_data[CHAN_W-1:0], q_blue));
  assign take = rd_pend && vld_q && (!have || (cand_dist < best_dist));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item_valid && (func == FUNC_QUERY)) state_next = ST_SCAN;
      ST_SCAN:   if (cnt == LAST_IDX) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: if (!result_valid || !result_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != ST_IDLE);
    issue      = (state == ST_SCAN);
    load_out   = (state == ST_FINISH) && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      rd_pend      <= 1'b0;
      have         <= 1'b0;
      result_valid <= 1'b0;
      entry_valid  <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (accept_qry) begin
        cnt  <= '0;
        have <= 1'b0;
      end else begin
        if (issue) cnt <= cnt + 1'b1;
        if (take) have <= 1'b1;
      end
      if (accept_wr && wr_in_range) entry_valid[wr_addr] <= 1'b1;
      if (load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_qry) begin
      q_red     <= red;
      q_green   <= green;
      q_blue    <= blue;
      best_idx  <= '0;
      best_dist <= '0;
    end else if (take) begin
      best_idx  <= rd_idx;
      best_dist <= cand_dist;
    end
    rd_idx <= cnt;
    vld_q  <= entry_valid[cnt];
    if (load_out) begin
      found          <= have;
      match_index    <= IDX_W'(best_idx);
      match_distance <= best_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_wr && wr_in_range) pal_mem[wr_addr] <= {red, green, blue};
    rd_data <= pal_mem[cnt];
  end

  `NPCS_ASSERT_NOW(a_empty_zero, clk, rst, result_valid && !found,
                   (match_index == '0) && (match_distance == '0))
  `NPCS_ASSERT_NEXT(a_query_scans, clk, rst, accept_qry, state == ST_SCAN)
  `NPCS_ASSERT_NEXT(a_write_silent, clk, rst, accept_wr && !result_valid, !result_valid)
  `NPCS_ASSERT_NEXT(a_scan_reads, clk, rst, state == ST_SCAN, rd_pend)

endmodule

`default_nettype wire
